### rtl/bfk_pkg.sv
// Package for the Blowfish-style cipher block: sizes, operation codes, helpers.
// No dependencies.
`timescale 1ns / 1ps
package bfk_pkg;
    localparam int TABLE_WORDS = 1042;
    localparam int ROUNDS      = 16;
    localparam int AW          = 11;
    localparam logic [AW-1:0] SBOX0 = 11'h012;
    localparam logic [AW-1:0] SBOX1 = 11'h112;
    localparam logic [AW-1:0] SBOX2 = 11'h212;
    localparam logic [AW-1:0] SBOX3 = 11'h312;
    localparam logic [AW-1:0] LAST_PAIR = 11'd1040;

    typedef enum logic [1:0] {
        OP_WRITE   = 2'd0,
        OP_ENCRYPT = 2'd1,
        OP_DECRYPT = 2'd2,
        OP_KEY     = 2'd3
    } t_op;

    typedef struct packed {
        logic        start;
        logic        decrypt;
        logic [31:0] w0;
        logic [31:0] w1;
    } t_cmd;

    function automatic logic [31:0] byte_swap(input logic [31:0] v);
        byte_swap = {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction
endpackage

### rtl/blowfish_key1_cipher.sv
// Top level of the Blowfish-style cipher: request handshake, key schedule sequencer.
// Depends on bfk_pkg, bfk_ram and bfk_core.
`timescale 1ns / 1ps
//  channel | signals                              | direction
//  request | i_valid, o_stall, op..key_level      | in
//  result  | o_valid, i_stall, o_out_lo, o_out_hi | out
// Encrypt/decrypt run 16 rounds of five table reads plus two
// final subkey reads, all through the single read port of the table RAM.
// Reset is synchronous and clears control and key code; table is not cleared.
// The result register holds under i_stall; one request is handled at a time.
module blowfish_key1_cipher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_op,
    input  logic [10:0] i_table_index,
    input  logic [31:0] i_table_value,
    input  logic [31:0] i_block_lo,
    input  logic [31:0] i_block_hi,
    input  logic [31:0] i_game_code,
    input  logic [1:0]  i_key_level,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_out_lo,
    output logic [31:0] o_out_hi
);
    import bfk_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_BLOCK, S_K1, S_K0, S_MIXR, S_MIXW, S_FILL, S_ADJ, S_OUT
    } t_state;

    t_state      r_state;
    logic [31:0] r_kc0, r_kc1, r_kc2;
    logic [1:0]  r_level, r_apps;
    logic [AW-1:0] r_idx;
    logic [31:0] r_a, r_b;
    logic        r_half;
    logic        r_valid;
    logic [31:0] r_lo, r_hi;
    logic        r_wait;

    t_cmd        n_cmd;
    logic [AW-1:0] core_addr;
    logic [31:0] rdata, core_w0, core_w1;
    logic        core_done;
    logic        we;
    logic [AW-1:0] waddr, raddr;
    logic [31:0] wdata;

    logic accept;
    assign accept  = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE) || r_valid;

    always_comb begin
        n_cmd = '0;
        we    = 1'b0;
        waddr = r_idx;
        wdata = '0;
        raddr = core_addr;
        unique case (r_state)
            S_IDLE: begin
                we    = accept && (t_op'(i_op) == OP_WRITE) && (i_table_index < AW'(TABLE_WORDS));
                waddr = i_table_index;
                wdata = i_table_value;
                n_cmd.start   = accept && (t_op'(i_op) == OP_ENCRYPT || t_op'(i_op) == OP_DECRYPT);
                n_cmd.decrypt = t_op'(i_op) == OP_DECRYPT;
                n_cmd.w0      = i_block_lo;
                n_cmd.w1      = i_block_hi;
            end
            S_K1: begin
                n_cmd.start = !r_wait;
                n_cmd.w0    = r_kc1;
                n_cmd.w1    = r_kc2;
            end
            S_K0: begin
                n_cmd.start = !r_wait;
                n_cmd.w0    = r_kc0;
                n_cmd.w1    = r_kc1;
            end
            S_MIXR: raddr = r_idx;
            S_MIXW: begin
                we    = 1'b1;
                wdata = rdata ^ byte_swap(r_idx[0] ? r_kc1 : r_kc0);
            end
            S_FILL: begin
                n_cmd.start = !r_wait;
                n_cmd.w0    = r_a;
                n_cmd.w1    = r_b;
                // word i takes the second word as the pair completes, word i+1 the first
                we    = r_half || core_done;
                waddr = r_half ? r_idx + AW'(1) : r_idx;
                wdata = r_half ? r_a : core_w1;
            end
            default: ;
        endcase
    end

    bfk_ram #(.WIDTH(32), .DEPTH(TABLE_WORDS)) u_table (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    bfk_core u_core (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (n_cmd),
        .o_raddr(core_addr),
        .i_rdata(rdata),
        .o_done (core_done),
        .o_w0   (core_w0),
        .o_w1   (core_w1)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_kc0   <= '0;
            r_kc1   <= '0;
            r_kc2   <= '0;
            r_wait  <= 1'b0;
            r_half  <= 1'b0;
        end else begin
            if (r_valid && !i_stall) begin
                r_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: if (accept) begin
                    r_lo <= '0;
                    r_hi <= '0;
                    unique case (t_op'(i_op))
                        OP_WRITE: r_valid <= 1'b1;
                        OP_ENCRYPT, OP_DECRYPT: r_state <= S_BLOCK;
                        OP_KEY: begin
                            r_kc0   <= i_game_code;
                            r_kc1   <= i_game_code >> 1;
                            r_kc2   <= i_game_code << 1;
                            r_level <= i_key_level;
                            r_apps  <= 2'd0;
                            r_wait  <= 1'b0;
                            r_state <= (i_key_level == 2'd0) ? S_ADJ : S_K1;
                        end
                        default: ;
                    endcase
                end
                S_BLOCK: if (core_done) begin
                    r_lo    <= core_w0;
                    r_hi    <= core_w1;
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_K1: begin
                    if (core_done) begin
                        r_kc1   <= core_w0;
                        r_kc2   <= core_w1;
                        r_wait  <= 1'b0;
                        r_state <= S_K0;
                    end else begin
                        r_wait  <= 1'b1;
                    end
                end
                S_K0: begin
                    if (core_done) begin
                        r_kc0   <= core_w0;
                        r_kc1   <= core_w1;
                        r_wait  <= 1'b0;
                        r_idx   <= '0;
                        r_state <= S_MIXR;
                    end else begin
                        r_wait  <= 1'b1;
                    end
                end
                S_MIXR: r_state <= S_MIXW;
                S_MIXW: begin
                    if (r_idx == AW'(ROUNDS + 1)) begin
                        r_idx   <= '0;
                        r_a     <= '0;
                        r_b     <= '0;
                        r_half  <= 1'b0;
                        r_state <= S_FILL;
                    end else begin
                        r_idx   <= r_idx + AW'(1);
                        r_state <= S_MIXR;
                    end
                end
                S_FILL: begin
                    if (r_half) begin
                        // second write of the pair: word i+1 gets a
                        r_half <= 1'b0;
                        r_wait <= 1'b0;
                        if (r_idx == LAST_PAIR) begin
                            r_apps <= r_apps + 2'd1;
                            if (r_apps + 2'd1 == 2'd2 || r_apps + 2'd1 == r_level) begin
                                r_state <= S_ADJ;
                            end else begin
                                r_state <= S_K1;
                            end
                        end else begin
                            r_idx <= r_idx + AW'(2);
                        end
                    end else begin
                        r_wait <= 1'b1;
                        if (core_done) begin
                            r_a    <= core_w0;
                            r_b    <= core_w1;
                            r_half <= 1'b1;
                        end
                    end
                end
                S_ADJ: begin
                    if (r_apps == 2'd3 || r_level != 2'd3 || r_apps != 2'd2) begin
                        r_valid <= 1'b1;
                        r_state <= S_IDLE;
                        if (r_apps != 2'd3) begin
                            r_kc1 <= r_kc1 << 1;
                            r_kc2 <= r_kc2 >> 1;
                        end
                    end else begin
                        r_kc1   <= r_kc1 << 1;
                        r_kc2   <= r_kc2 >> 1;
                        r_state <= S_K1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid  = r_valid;
    assign o_out_lo = r_lo;
    assign o_out_hi = r_hi;
endmodule

### rtl/bfk_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module bfk_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1042
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### rtl/bfk_core.sv
// Round engine: runs one 16-round encryption or decryption through the table.
// Depends on bfk_pkg; reads the table through an external RAM read port.
`timescale 1ns / 1ps
module bfk_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  bfk_pkg::t_cmd        i_cmd,
    output logic [bfk_pkg::AW-1:0] o_raddr,
    input  logic [31:0]          i_rdata,
    output logic                 o_done,
    output logic [31:0]          o_w0,
    output logic [31:0]          o_w1
);
    import bfk_pkg::*;

    // per round: read P, then four S-box reads; final: two P reads
    typedef enum logic [2:0] {S_IDLE, S_P, S_S0, S_S1, S_S2, S_S3, S_F0, S_F1} t_state;

    t_state      r_state;
    logic [4:0]  r_round;
    logic        r_dec;
    logic [31:0] r_x, r_y, r_z, r_f;
    logic        r_done;
    logic [31:0] r_o0, r_o1;
    logic [AW-1:0] n_addr;
    logic [31:0] i_rdata_z;

    assign i_rdata_z = i_rdata ^ r_x;

    always_comb begin
        n_addr = '0;
        unique case (r_state)
            S_IDLE: n_addr = i_cmd.decrypt ? AW'(ROUNDS + 1) : '0;
            S_P:    n_addr = SBOX0 + AW'(i_rdata_z[31:24]);
            S_S0:   n_addr = SBOX1 + AW'(r_z[23:16]);
            S_S1:   n_addr = SBOX2 + AW'(r_z[15:8]);
            S_S2:   n_addr = SBOX3 + AW'(r_z[7:0]);
            S_S3:   n_addr = (r_round == 5'(ROUNDS - 1))
                             ? (r_dec ? AW'(1) : AW'(ROUNDS))
                             : AW'(r_dec ? 5'(ROUNDS) - r_round : r_round + 5'd1);
            S_F0:   n_addr = r_dec ? AW'(0) : AW'(ROUNDS + 1);
            default: n_addr = '0;
        endcase
    end

    assign o_raddr   = n_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_round <= '0;
            r_dec   <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_cmd.start) begin
                    r_x     <= i_cmd.w1;
                    r_y     <= i_cmd.w0;
                    r_dec   <= i_cmd.decrypt;
                    r_round <= '0;
                    r_state <= S_P;
                end
                S_P: begin
                    r_z     <= i_rdata_z;
                    r_state <= S_S0;
                end
                S_S0: begin
                    r_f     <= i_rdata;
                    r_state <= S_S1;
                end
                S_S1: begin
                    r_f     <= i_rdata + r_f;
                    r_state <= S_S2;
                end
                S_S2: begin
                    r_f     <= i_rdata ^ r_f;
                    r_state <= S_S3;
                end
                S_S3: begin
                    r_x <= r_y ^ (i_rdata + r_f);
                    r_y <= r_z;
                    if (r_round == 5'(ROUNDS - 1)) begin
                        r_state <= S_F0;
                    end else begin
                        r_round <= r_round + 5'd1;
                        r_state <= S_P;
                    end
                end
                S_F0: begin
                    r_o0    <= r_x ^ i_rdata;
                    r_state <= S_F1;
                end
                S_F1: begin
                    r_o1    <= r_y ^ i_rdata;
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_w0   = r_o0;
    assign o_w1   = r_o1;
endmodule

### rtl/bfk_check.sv
// Port-level checker for the cipher top level, attached by bind.
// Depends on blowfish_key1_cipher ports only.
`timescale 1ns / 1ps
module bfk_check (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_out_lo,
    input logic [31:0] o_out_hi
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_lo) && $stable(o_out_hi))
        else $error("result changed under stall");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("request taken while result pending");
    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("second request accepted back to back");
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");
endmodule

bind blowfish_key1_cipher bfk_check u_bfk_check (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_out_lo(o_out_lo),
    .o_out_hi(o_out_hi)
);
